// File: hw/rtl/compacting_key_list_defines.svh
// ---------------------------------------------------------------------------
// Compacting key list assertion macros
// Shared forms for the concurrent checks of the key list.
// ---------------------------------------------------------------------------
`ifndef COMPACTING_KEY_LIST_DEFINES_SVH
`define COMPACTING_KEY_LIST_DEFINES_SVH

// The condition implies the check in the same cycle.
`define CKL_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);

// The condition implies the check in the next cycle.
`define CKL_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);

`endif

// File: hw/rtl/ckl_pkg.sv
// ---------------------------------------------------------------------------
// Compacting key list package
// Word types and command and status codes for the key list.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ckl_pkg;

  localparam int KEY_W   = 64;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_MISS      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] position;
  } ckl_cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   read_key;
    logic [COUNT_W-1:0] count;
  } ckl_rsp_t;

endpackage

// File: hw/rtl/compacting_key_list.sv
// ---------------------------------------------------------------------------
// Compacting key list
// Fixed-capacity ordered list of keys with append, remove with compaction,
// indexed read and clear.
// ---------------------------------------------------------------------------
//
//   channel   words      handshake          direction
//   cmd       ckl_cmd_t  cmd_valid/cmd_stall  into the block
//   rsp       ckl_rsp_t  rsp_valid/rsp_stall  out of the block
//
// Insert and clear go from idle straight to the finish state, a read that hits
// passes through the read state first, and a refused read or a remove from an
// empty list goes straight to finish. A remove from a non-empty list scans every
// entry in the remove state: the single memory read port fetches one entry a
// cycle for the compare, and the write port moves each later entry down.
// Reset clears the fill count at once; the entry memory is not cleared.
// A command is taken only while idle; a waiting response holds in the output
// register while the next command is taken and worked on.
`timescale 1ns / 1ps

module compacting_key_list #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  ckl_pkg::ckl_cmd_t cmd,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ckl_pkg::ckl_rsp_t rsp
);

  import ckl_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_REMOVE,
    S_FINISH
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    scan;
  logic                dat_ok;
  logic [IDX_W-1:0]    dat_idx;
  logic                found;
  logic [1:0]          pend_status;
  logic [KEY_BITS-1:0] pend_key;

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  logic                accept;
  logic [KEY_BITS-1:0] cmd_key;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_cmp;
  logic [EXT_W-1:0]    cnt_out;
  logic                full;
  logic                issue;
  logic                match;
  logic                last;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_key   = cmd.key[KEY_BITS-1:0];
  assign pos_ext   = CMP_W'(cmd.position);
  assign cnt_cmp   = CMP_W'(count);
  assign cnt_out   = EXT_W'(count);
  assign full      = (count >= CNT_W'(CAPACITY));
  assign issue     = (scan < count);
  assign match     = (rd_data == key_r);
  assign last      = (CNT_W'(dat_idx) == (count - CNT_W'(1)));

  always_comb begin
    rd_addr = scan[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = cmd_key;
    if (state == S_IDLE) begin
      rd_addr = pos_ext[IDX_W-1:0];
      wr_en   = accept && (cmd.command == CMD_INSERT) && !full;
    end else if (state == S_REMOVE) begin
      wr_en   = dat_ok && found;
      wr_addr = dat_idx - IDX_W'(1);
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          pend_key <= '0;
          scan     <= '0;
          dat_ok   <= 1'b0;
          found    <= 1'b0;
          key_r    <= cmd_key;
          if (accept) begin
            unique case (cmd.command)
              CMD_INSERT: begin
                state <= S_FINISH;
                if (full) begin
                  pend_status <= ST_FULL;
                end else begin
                  pend_status <= ST_DONE;
                  count       <= count + CNT_W'(1);
                end
              end
              CMD_REMOVE: begin
                if (count == '0) begin
                  pend_status <= ST_MISS;
                  state       <= S_FINISH;
                end else begin
                  state <= S_REMOVE;
                end
              end
              CMD_READ: begin
                if (count == '0) begin
                  pend_status <= ST_MISS;
                  state       <= S_FINISH;
                end else if (pos_ext >= cnt_cmp) begin
                  pend_status <= ST_BAD_INDEX;
                  state       <= S_FINISH;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                count       <= '0;
                pend_status <= ST_DONE;
                state       <= S_FINISH;
              end
            endcase
          end
        end
        S_READ: begin
          pend_status <= ST_DONE;
          pend_key    <= rd_data;
          state       <= S_FINISH;
        end
        S_REMOVE: begin
          dat_ok  <= issue;
          dat_idx <= scan[IDX_W-1:0];
          if (issue) begin
            scan <= scan + CNT_W'(1);
          end
          if (dat_ok && !found && match) begin
            found <= 1'b1;
          end
          if (dat_ok && last) begin
            state <= S_FINISH;
            if (found || match) begin
              pend_status <= ST_DONE;
              count       <= count - CNT_W'(1);
            end else begin
              pend_status <= ST_MISS;
            end
          end
        end
        default: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            rsp.status   <= pend_status;
            rsp.read_key <= KEY_W'(pend_key);
            rsp.count    <= cnt_out[COUNT_W-1:0];
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

`include "compacting_key_list_defines.svh"

  `CKL_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `CKL_ASSERT_NEXT(a_insert_grows, accept && cmd.command == CMD_INSERT && !full, count == $past(count) + CNT_W'(1), "insert did not grow the list")
  `CKL_ASSERT_NOW(a_full_count, rsp_valid && rsp.status == ST_FULL, rsp.count == COUNT_W'(CAPACITY), "full status with a list that is not full")
  `CKL_ASSERT_NOW(a_key_on_done, rsp_valid && rsp.read_key != '0, rsp.status == ST_DONE, "read key on a failed command")

endmodule

// File: tb/compacting_key_list_tb.sv
// ---------------------------------------------------------------------------
// Compacting key list testbench
// Drives insert, remove, read and clear words into the key list and checks
// every reply against a table row's typed reply or a shadow copy of the list
// kept in the testbench. A short table covers the empty, full, duplicate and
// bad-index cases first, then random words with shifting insert and remove bias
// fill and drain the list many times, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module compacting_key_list_tb;
  import ckl_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_WORDS = 1800;
  localparam int QUIET_TAIL   = 300;

  typedef struct {
    ckl_cmd_t word;
    int       reps;
    bit       typed;
    ckl_rsp_t reply;
  } table_row_t;

  logic     clk;
  logic     rst       = 1'b1;
  logic     cmd_valid = 1'b0;
  logic     cmd_stall;
  ckl_cmd_t cmd       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  ckl_rsp_t rsp;

  logic [KEY_W-1:0] shadow_keys [LIST_DEPTH];
  int               shadow_fill = 0;
  ckl_rsp_t         awaited_replies [$];
  ckl_rsp_t         want;
  int               error_count = 0;
  bit               send_idle   = 1'b1;
  bit               recv_idle   = 1'b1;
  int               stall_left  = 0;

  compacting_key_list DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic ckl_rsp_t apply_to_shadow_list(input ckl_cmd_t w);
    ckl_rsp_t r;
    int       hit;
    r = '0;
    r.status = ST_DONE;
    case (w.command)
      CMD_INSERT: begin
        if (shadow_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_fill] = w.key;
          shadow_fill++;
        end
      end
      CMD_REMOVE: begin
        hit = -1;
        for (int i = 0; i < shadow_fill; i++) begin
          if (hit < 0 && shadow_keys[i] == w.key) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          for (int i = hit + 1; i < shadow_fill; i++) shadow_keys[i-1] = shadow_keys[i];
          shadow_fill--;
        end
      end
      CMD_READ: begin
        if (shadow_fill == 0) begin
          r.status = ST_MISS;
        end else if (int'(w.position) >= shadow_fill) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.read_key = shadow_keys[w.position];
        end
      end
      default: begin
        shadow_fill = 0;
      end
    endcase
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(KEY_W-1){1'b0}}};
      3, 4, 5: return KEY_W'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(input ckl_cmd_t w, input bit typed, input ckl_rsp_t reply);
    ckl_rsp_t predicted;
    cmd_valid <= 1'b1;
    cmd       <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    predicted = apply_to_shadow_list(w);
    awaited_replies.push_back(typed ? reply : predicted);
    if (send_idle && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("reply word with none awaited: status %0d count %0d", rsp.status, rsp.count);
          error_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            error_count++;
          end
          if (rsp.read_key !== want.read_key) begin
            $error("read_key: expected %h, got %h", want.read_key, rsp.read_key);
            error_count++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall  <= 1'b1;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 12);
        rsp_stall  <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    table_row_t  plan [25];
    ckl_cmd_t    w;
    int          bias;
    int          pick;
    int unsigned idle_mode;

    plan = '{
      '{'{CMD_READ,   64'h0,                  4'd0},  1, 1'b1, '{ST_MISS,      64'h0, 5'd0}},
      '{'{CMD_REMOVE, 64'h0,                  4'd0},  1, 1'b1, '{ST_MISS,      64'h0, 5'd0}},
      '{'{CMD_INSERT, 64'h0,                  4'd0},  1, 1'b1, '{ST_DONE,      64'h0, 5'd1}},
      '{'{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0}, 1, 1'b1, '{ST_DONE,      64'h0, 5'd2}},
      '{'{CMD_READ,   64'h0,                  4'd1},  1, 1'b1,
        '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2}},
      '{'{CMD_READ,   64'h0,                  4'd15}, 1, 1'b1, '{ST_BAD_INDEX, 64'h0, 5'd2}},
      '{'{CMD_READ,   64'h0,                  4'd2},  1, 1'b1, '{ST_BAD_INDEX, 64'h0, 5'd2}},
      '{'{CMD_REMOVE, 64'h1234,               4'd0},  1, 1'b1, '{ST_MISS,      64'h0, 5'd2}},
      '{'{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0}, 1, 1'b1, '{ST_DONE,      64'h0, 5'd3}},
      '{'{CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0}, 1, 1'b1, '{ST_DONE,      64'h0, 5'd2}},
      '{'{CMD_READ,   64'h0,                  4'd1},  1, 1'b1,
        '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd2}},
      '{'{CMD_REMOVE, 64'h0,                  4'd0},  1, 1'b1, '{ST_DONE,      64'h0, 5'd1}},
      '{'{CMD_READ,   64'h0,                  4'd0},  1, 1'b1,
        '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd1}},
      '{'{CMD_CLEAR,  64'h0,                  4'd0},  1, 1'b1, '{ST_DONE,      64'h0, 5'd0}},
      '{'{CMD_READ,   64'h0,                  4'd0},  1, 1'b1, '{ST_MISS,      64'h0, 5'd0}},
      '{'{CMD_INSERT, 64'hA5A5_0000_0000_0000, 4'd0}, 16, 1'b0, '{ST_DONE,     64'h0, 5'd0}},
      '{'{CMD_INSERT, 64'h8000_0000_0000_0000, 4'd0}, 1, 1'b1, '{ST_FULL,      64'h0, 5'd16}},
      '{'{CMD_READ,   64'h0,                  4'd15}, 1, 1'b1,
        '{ST_DONE, 64'hA5A5_0000_0000_000F, 5'd16}},
      '{'{CMD_REMOVE, 64'hA5A5_0000_0000_0000, 4'd0}, 1, 1'b1, '{ST_DONE,      64'h0, 5'd15}},
      '{'{CMD_READ,   64'h0,                  4'd0},  1, 1'b1,
        '{ST_DONE, 64'hA5A5_0000_0000_0001, 5'd15}},
      '{'{CMD_READ,   64'h0,                  4'd15}, 1, 1'b1, '{ST_BAD_INDEX, 64'h0, 5'd15}},
      '{'{CMD_REMOVE, 64'hA5A5_0000_0000_000F, 4'd0}, 1, 1'b1, '{ST_DONE,      64'h0, 5'd14}},
      '{'{CMD_REMOVE, 64'h8000_0000_0000_0000, 4'd0}, 1, 1'b1, '{ST_MISS,      64'h0, 5'd14}},
      '{'{CMD_READ,   64'h0,                  4'd13}, 1, 1'b1,
        '{ST_DONE, 64'hA5A5_0000_0000_000E, 5'd14}},
      '{'{CMD_CLEAR,  64'h0,                  4'd0},  1, 1'b1, '{ST_DONE,      64'h0, 5'd0}}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The fill row repeats with the key stepping up by one each word.
    foreach (plan[n]) begin
      for (int r = 0; r < plan[n].reps; r++) begin
        w = plan[n].word;
        w.key = w.key + KEY_W'(r);
        send_word(w, plan[n].typed, plan[n].reply);
      end
    end

    bias = 1;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 150 == 0) begin
        idle_mode = $urandom_range(0, 3);
        send_idle = idle_mode[0];
        recv_idle = idle_mode[1];
      end
      if (k >= RANDOM_WORDS - QUIET_TAIL) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      if (k % 60 == 0) bias = $urandom_range(0, 2);

      // Bias 0 fills the list, bias 1 is balanced, bias 2 drains it.
      pick = $urandom_range(0, 99);
      w.key      = pick_key();
      w.position = 4'($urandom_range(0, 15));
      if (pick < 2) begin
        w.command = CMD_CLEAR;
      end else if (pick < 2 + (bias == 0 ? 58 : (bias == 1 ? 35 : 18))) begin
        w.command = CMD_INSERT;
      end else if (pick < 75) begin
        w.command = CMD_READ;
        if (shadow_fill > 0 && $urandom_range(0, 4) != 0) begin
          w.position = 4'($urandom_range(0, shadow_fill - 1));
        end
      end else begin
        w.command = CMD_REMOVE;
        if (shadow_fill > 0 && $urandom_range(0, 9) < 7) begin
          w.key = shadow_keys[$urandom_range(0, shadow_fill - 1)];
        end
      end
      if (bias == 2 && w.command == CMD_READ && $urandom_range(0, 1) == 0) begin
        w.command = CMD_REMOVE;
        if (shadow_fill > 0) w.key = shadow_keys[$urandom_range(0, shadow_fill - 1)];
      end
      send_word(w, 1'b0, '0);
    end
    cmd_valid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
